### src/lape_pkg.sv
// Package for the line and arc path evaluator: codes, segment record,
// fixed-point constants, series tables and state types.
// Depends on nothing; used by line_arc_path_evaluator and lape_sincos.
package lape_pkg;

  // Default table depth.
  localparam int MAX_SEGMENTS_DEF = 8;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2
  } op_e;

  // Result status codes carried in the output tuser.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  // One stored path segment.
  typedef struct packed {
    logic        kind;
    logic [31:0] length;
    logic [31:0] north;
    logic [31:0] east;
    logic [15:0] heading;
    logic [31:0] curv;
    logic [31:0] offset;
  } seg_t;

  // Fixed-point constants.
  localparam logic [31:0] PI_Q30       = 32'hC90F_DAA2;
  localparam logic [63:0] INV_TWO_PI   = 64'h28BE_60DB_9391_054A;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam int          ARC_MIN_CURV = 17;
  localparam int          SERIES_LEN   = 6;

  // Series divisors and their reciprocals floor(2^32 / d).
  localparam logic [7:0]  SIN_DIV [SERIES_LEN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0]  COS_DIV [SERIES_LEN] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_REC [SERIES_LEN] = '{32'd27531841, 32'd39045157, 32'd59652323,
                                                   32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_REC [SERIES_LEN] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                                   32'd143165576, 32'd357913941, 32'd2147483648};

  // Sine/cosine unit request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } sc_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] sin;
    logic [31:0] cos;
  } sc_rsp_t;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_SETUP, ST_ABSK, ST_ADV, ST_SC0, ST_LINE,
    ST_SC1, ST_DIVSET, ST_DIV, ST_FORM, ST_RESP
  } evl_state_e;

  // Sine/cosine unit states.
  typedef enum logic [2:0] {
    SC_IDLE, SC_XMUL, SC_X2, SC_HMUL, SC_HREC, SC_HFIX, SC_FIN, SC_MAP
  } sc_state_e;

  // Saturate a 36-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### src/line_arc_path_evaluator.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: seg_length, start_north, start_east, seg_heading,
//                seg_curvature, arc_pos; tuser: operation, seg_kind
// m_axis    out  tdata: pos_north, pos_east, heading, curvature; tuser: status
// One item is processed at a time.
// Evaluate searches all N stored segments, then runs the shared sine/cosine
// unit once on lines and near-straight arcs and twice on arcs, where the
// 35-step bit-serial divider follows.
// The segment table is one RAM read once per cycle during the search.
// Reset clears the segment count and total; the table needs no clearing pass.
// A waiting result sits in the output register while the next item is taken.
// Depends on lape_pkg, lape_ram and lape_sincos.
module line_arc_path_evaluator #(
  parameter int MAX_SEGMENTS = lape_pkg::MAX_SEGMENTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seg_length, start_north, start_east, seg_heading, seg_curvature, arc_pos
  input  logic [175:0] s_axis_tdata,
  // operation, seg_kind
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_north, pos_east, heading, curvature
  output logic [111:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int AddrW = $clog2(MAX_SEGMENTS);
  localparam int CntW  = $clog2(MAX_SEGMENTS + 1);
  localparam int SegW  = $bits(lape_pkg::seg_t);
  localparam int DivN  = 35;

  lape_pkg::evl_state_e state_q, state_d;

  logic [CntW-1:0]   count_q, scan_q;
  logic [31:0]       total_q, spos_q;
  logic              pend_q;
  lape_pkg::seg_t    seg_q, rd_seg, wr_seg;
  logic [31:0]       t_q, absk_q, p1_q;
  logic [63:0]       p_q, pp_q;
  logic [95:0]       acc_q;
  logic [2:0]        advc_q;
  logic [31:0]       sn0_q, cs0_q, sn1_q, cs1_q;
  logic [62:0]       lprodn_q, lprode_q;
  logic              lnegn_q, lnege_q;
  logic [5:0]        divc_q;
  logic [34:0]       dvdn_q, dvde_q;
  logic [32:0]       remn_q, reme_q, dvs_q;
  logic              negn_q, nege_q;
  logic [31:0]       rn_q, re_q, rk_q;
  logic [15:0]       rh_q;
  lape_pkg::status_e stat_q;
  logic              m_valid_q;
  logic [111:0]      m_data_q;
  logic [1:0]        m_user_q;

  lape_pkg::op_e     in_op;
  logic              in_acc, full, ram_we, use_arc, res_load;
  logic [31:0]       k;
  logic [31:0]       base;
  lape_pkg::sc_req_t sc_req;
  lape_pkg::sc_rsp_t sc_rsp;

  assign in_op   = lape_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign full    = (count_q >= CntW'(MAX_SEGMENTS));
  assign ram_we  = in_acc && (in_op == lape_pkg::OP_APPEND) && !full;
  assign k       = seg_q.curv;
  assign base    = {seg_q.heading, 16'd0};
  assign use_arc = seg_q.kind && (($signed(k) >= 32'sd17) || ($signed(k) <= -32'sd17));
  assign res_load = (state_q == lape_pkg::ST_RESP) && (!m_valid_q || m_axis_tready);

  // New record: the running total becomes the start offset.
  assign wr_seg = '{kind:    s_axis_tuser[2],
                    length:  s_axis_tdata[31:0],
                    north:   s_axis_tdata[63:32],
                    east:    s_axis_tdata[95:64],
                    heading: s_axis_tdata[111:96],
                    curv:    s_axis_tdata[143:112],
                    offset:  total_q};

  // Segment table. Writes happen only in idle and reads only during the
  // search, so the two never meet on one entry.
  lape_ram #(
    .WIDTH (SegW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wr_seg),
    .raddr_i (scan_q[AddrW-1:0]),
    .rdata_o (rd_seg)
  );

  lape_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sc_req),
    .rsp_o  (sc_rsp)
  );

  // State, table fill and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [32:0] tsum;
    if (!rst_ni) begin
      state_q   <= lape_pkg::ST_IDLE;
      count_q   <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        case (in_op)
          lape_pkg::OP_CLEAR: begin
            count_q <= '0;
            total_q <= '0;
          end
          lape_pkg::OP_APPEND: begin
            if (!full) begin
              tsum    = {1'b0, total_q} + {1'b0, s_axis_tdata[31:0]};
              count_q <= count_q + CntW'(1);
              total_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            end
          end
          default: ;
        endcase
      end
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Next state and unit requests.
  always_comb begin
    state_d        = state_q;
    s_axis_tready  = 1'b0;
    sc_req.start   = 1'b0;
    sc_req.angle   = (state_q == lape_pkg::ST_ADV) ? base : p1_q;
    unique case (state_q)
      lape_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_op == lape_pkg::OP_EVAL && count_q != '0) begin
            state_d = lape_pkg::ST_SEARCH;
          end else begin
            state_d = lape_pkg::ST_RESP;
          end
        end
      end
      lape_pkg::ST_SEARCH: begin
        if (scan_q == count_q && !pend_q) state_d = lape_pkg::ST_SETUP;
      end
      lape_pkg::ST_SETUP: state_d = lape_pkg::ST_ABSK;
      lape_pkg::ST_ABSK:  state_d = lape_pkg::ST_ADV;
      lape_pkg::ST_ADV: begin
        if (advc_q == 3'd4) begin
          sc_req.start = 1'b1;
          state_d      = lape_pkg::ST_SC0;
        end
      end
      lape_pkg::ST_SC0: if (sc_rsp.done) state_d = lape_pkg::ST_LINE;
      lape_pkg::ST_LINE: begin
        if (use_arc) begin
          sc_req.start = 1'b1;
          state_d      = lape_pkg::ST_SC1;
        end else begin
          state_d = lape_pkg::ST_FORM;
        end
      end
      lape_pkg::ST_SC1:    if (sc_rsp.done) state_d = lape_pkg::ST_DIVSET;
      lape_pkg::ST_DIVSET: state_d = lape_pkg::ST_DIV;
      lape_pkg::ST_DIV:    if (divc_q == 6'(DivN - 1)) state_d = lape_pkg::ST_FORM;
      lape_pkg::ST_FORM:   state_d = lape_pkg::ST_RESP;
      lape_pkg::ST_RESP:   if (!m_valid_q || m_axis_tready) state_d = lape_pkg::ST_IDLE;
      default:             state_d = lape_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    logic [31:0] tl, d32, adv, cabs, sabs;
    logic [95:0] addend;
    logic [34:0] nn, ne, an, ae;
    logic [33:0] trn, tre;
    logic [63:0] rs;
    logic signed [35:0] offn, offe;
    if (res_load) begin
      m_data_q <= {rk_q, rh_q, re_q, rn_q};
      m_user_q <= stat_q;
    end
    case (state_q)
      lape_pkg::ST_IDLE: begin
        spos_q <= (s_axis_tdata[175:144] > total_q) ? total_q : s_axis_tdata[175:144];
        scan_q <= '0;
        pend_q <= 1'b0;
        rn_q   <= '0;
        re_q   <= '0;
        rh_q   <= '0;
        rk_q   <= '0;
        case (in_op)
          lape_pkg::OP_CLEAR:  stat_q <= lape_pkg::STAT_CLEARED;
          lape_pkg::OP_APPEND: stat_q <= full ? lape_pkg::STAT_FULL : lape_pkg::STAT_DONE;
          lape_pkg::OP_EVAL: begin
            stat_q <= (count_q == '0) ? lape_pkg::STAT_EMPTY : lape_pkg::STAT_DONE;
          end
          default:             stat_q <= lape_pkg::STAT_DONE;
        endcase
      end
      lape_pkg::ST_SEARCH: begin
        // Offsets rise with the index, so the last match is the segment.
        if (scan_q < count_q) begin
          scan_q <= scan_q + CntW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q && spos_q >= rd_seg.offset) seg_q <= rd_seg;
      end
      lape_pkg::ST_SETUP: begin
        tl     = spos_q - seg_q.offset;
        t_q    <= (tl > seg_q.length) ? seg_q.length : tl;
        absk_q <= k[31] ? (32'd0 - k) : k;
        advc_q <= 3'd0;
        acc_q  <= '0;
      end
      lape_pkg::ST_ABSK: p_q <= 64'(absk_q) * 64'(t_q);
      lape_pkg::ST_ADV: begin
        // |k|*t times 1/(2*pi) in four partial products.
        case (advc_q[1:0])
          2'd0:    pp_q <= 64'(p_q[31:0])  * 64'(lape_pkg::INV_TWO_PI[31:0]);
          2'd1:    pp_q <= 64'(p_q[31:0])  * 64'(lape_pkg::INV_TWO_PI[63:32]);
          2'd2:    pp_q <= 64'(p_q[63:32]) * 64'(lape_pkg::INV_TWO_PI[31:0]);
          default: pp_q <= 64'(p_q[63:32]) * 64'(lape_pkg::INV_TWO_PI[63:32]);
        endcase
        case (advc_q)
          3'd1:    addend = {32'd0, pp_q};
          3'd2,
          3'd3:    addend = {pp_q, 32'd0};
          3'd4:    addend = {pp_q[31:0], 64'd0};
          default: addend = '0;
        endcase
        acc_q  <= acc_q + addend;
        advc_q <= advc_q + 3'd1;
      end
      lape_pkg::ST_SC0: begin
        d32  = acc_q[95:64] + {31'd0, acc_q[63]};
        adv  = k[31] ? (32'd0 - d32) : d32;
        p1_q <= base + adv;
        if (sc_rsp.done) begin
          sn0_q <= sc_rsp.sin;
          cs0_q <= sc_rsp.cos;
        end
      end
      lape_pkg::ST_LINE: begin
        cabs     = cs0_q[31] ? (32'd0 - cs0_q) : cs0_q;
        sabs     = sn0_q[31] ? (32'd0 - sn0_q) : sn0_q;
        lprodn_q <= 63'(t_q) * 63'(cabs[30:0]);
        lprode_q <= 63'(t_q) * 63'(sabs[30:0]);
        lnegn_q  <= cs0_q[31];
        lnege_q  <= sn0_q[31];
      end
      lape_pkg::ST_SC1: begin
        if (sc_rsp.done) begin
          sn1_q <= sc_rsp.sin;
          cs1_q <= sc_rsp.cos;
        end
      end
      lape_pkg::ST_DIVSET: begin
        nn     = ({{3{sn1_q[31]}}, sn1_q} - {{3{sn0_q[31]}}, sn0_q}) << 2;
        ne     = ({{3{cs0_q[31]}}, cs0_q} - {{3{cs1_q[31]}}, cs1_q}) << 2;
        an     = nn[34] ? (35'd0 - nn) : nn;
        ae     = ne[34] ? (35'd0 - ne) : ne;
        dvdn_q <= {an[33:0], 1'b0} + 35'(absk_q);
        dvde_q <= {ae[33:0], 1'b0} + 35'(absk_q);
        dvs_q  <= {absk_q, 1'b0};
        remn_q <= '0;
        reme_q <= '0;
        negn_q <= nn[34] ^ k[31];
        nege_q <= ne[34] ^ k[31];
        divc_q <= '0;
      end
      lape_pkg::ST_DIV: begin
        // Restoring division, one quotient bit a cycle for each axis.
        trn = {remn_q, dvdn_q[34]};
        tre = {reme_q, dvde_q[34]};
        if (trn >= {1'b0, dvs_q}) begin
          remn_q <= 33'(trn - {1'b0, dvs_q});
          dvdn_q <= {dvdn_q[33:0], 1'b1};
        end else begin
          remn_q <= trn[32:0];
          dvdn_q <= {dvdn_q[33:0], 1'b0};
        end
        if (tre >= {1'b0, dvs_q}) begin
          reme_q <= 33'(tre - {1'b0, dvs_q});
          dvde_q <= {dvde_q[33:0], 1'b1};
        end else begin
          reme_q <= tre[32:0];
          dvde_q <= {dvde_q[33:0], 1'b0};
        end
        divc_q <= divc_q + 6'd1;
      end
      lape_pkg::ST_FORM: begin
        if (use_arc) begin
          offn = negn_q ? -$signed({1'b0, dvdn_q}) : $signed({1'b0, dvdn_q});
          offe = nege_q ? -$signed({1'b0, dvde_q}) : $signed({1'b0, dvde_q});
        end else begin
          rs   = 64'(lprodn_q) + 64'h2000_0000;
          offn = lnegn_q ? -$signed({2'b0, rs[63:30]}) : $signed({2'b0, rs[63:30]});
          rs   = 64'(lprode_q) + 64'h2000_0000;
          offe = lnege_q ? -$signed({2'b0, rs[63:30]}) : $signed({2'b0, rs[63:30]});
        end
        rn_q <= lape_pkg::sat32($signed({{4{seg_q.north[31]}}, seg_q.north}) + offn);
        re_q <= lape_pkg::sat32($signed({{4{seg_q.east[31]}}, seg_q.east}) + offe);
        if (seg_q.kind) begin
          d32  = p1_q + 32'h0000_8000;
          rh_q <= d32[31:16];
          rk_q <= k;
        end else begin
          rh_q <= seg_q.heading;
          rk_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The table never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SEGMENTS))
    else $error("segment count above table depth");

  // A clear empties the table on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == lape_pkg::OP_CLEAR) |=> (count_q == '0 && total_q == '0))
    else $error("clear did not empty the table");

  // An append with room adds exactly one segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == lape_pkg::OP_APPEND && !full) |=>
      (count_q == $past(count_q) + CntW'(1)))
    else $error("append did not add one segment");

  // The running total only falls through a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q < $past(total_q)) |-> $past(in_acc && in_op == lape_pkg::OP_CLEAR))
    else $error("total length fell without a clear");

  // Sine/cosine results arrive only while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_rsp.done |-> (state_q == lape_pkg::ST_SC0 || state_q == lape_pkg::ST_SC1))
    else $error("sine/cosine result outside a wait state");

endmodule

### src/lape_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lape_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lape_sincos.sv
// Iterative sine and cosine of a 32-bit binary angle, Q30 results.
// Folds to the nearest quarter turn, then runs Horner series on one shared step.
// Depends on lape_pkg.
module lape_sincos (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lape_pkg::sc_req_t req_i,
  output lape_pkg::sc_rsp_t rsp_o
);

  lape_pkg::sc_state_e state_q, state_d;

  logic [29:0] mag_q;
  logic [1:0]  quad_q;
  logic        neg_q;
  logic [29:0] x_q, x2_q;
  logic [30:0] hs_q, hc_q, vs_q, vc_q, qs_q, qc_q, sn_q;
  logic [2:0]  it_q;
  logic [31:0] sin_q, cos_q;
  logic        done_q;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lape_pkg::SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lape_pkg::SC_MAP);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lape_pkg::SC_IDLE: if (req_i.start) state_d = lape_pkg::SC_XMUL;
      lape_pkg::SC_XMUL: state_d = lape_pkg::SC_X2;
      lape_pkg::SC_X2:   state_d = lape_pkg::SC_HMUL;
      lape_pkg::SC_HMUL: state_d = lape_pkg::SC_HREC;
      lape_pkg::SC_HREC: state_d = lape_pkg::SC_HFIX;
      lape_pkg::SC_HFIX: begin
        state_d = (it_q == 3'(lape_pkg::SERIES_LEN - 1)) ? lape_pkg::SC_FIN
                                                         : lape_pkg::SC_HMUL;
      end
      lape_pkg::SC_FIN:  state_d = lape_pkg::SC_MAP;
      lape_pkg::SC_MAP:  state_d = lape_pkg::SC_IDLE;
      default:           state_d = lape_pkg::SC_IDLE;
    endcase
  end

  // Datapath: one or two multiplies per step, registered.
  always_ff @(posedge clk_i) begin
    logic [31:0] sum, r, mabs;
    logic [62:0] px;
    logic [60:0] ph;
    logic [62:0] pr;
    logic [30:0] fs, fc;
    logic [31:0] s0, c0;
    case (state_q)
      lape_pkg::SC_IDLE: begin
        sum    = req_i.angle + 32'h2000_0000;
        r      = req_i.angle - {sum[31:30], 30'd0};
        mabs   = r[31] ? (32'd0 - r) : r;
        quad_q <= sum[31:30];
        neg_q  <= r[31];
        mag_q  <= mabs[29:0];
        hs_q   <= lape_pkg::Q30_ONE;
        hc_q   <= lape_pkg::Q30_ONE;
        it_q   <= 3'd0;
      end
      lape_pkg::SC_XMUL: begin
        px  = 63'(mag_q) * 63'(lape_pkg::PI_Q30) + 63'h4000_0000;
        x_q <= px[60:31];
      end
      lape_pkg::SC_X2: begin
        ph   = 61'(x_q) * 61'(x_q) + 61'h2000_0000;
        x2_q <= ph[59:30];
      end
      lape_pkg::SC_HMUL: begin
        ph   = 61'(x2_q) * 61'(hs_q) + 61'h2000_0000;
        vs_q <= ph[60:30];
        ph   = 61'(x2_q) * 61'(hc_q) + 61'h2000_0000;
        vc_q <= ph[60:30];
      end
      lape_pkg::SC_HREC: begin
        // Quotient estimate by reciprocal, low by at most one.
        pr   = 63'(vs_q) * 63'(lape_pkg::SIN_REC[it_q]);
        qs_q <= pr[62:32];
        pr   = 63'(vc_q) * 63'(lape_pkg::COS_REC[it_q]);
        qc_q <= pr[62:32];
      end
      lape_pkg::SC_HFIX: begin
        fs   = vs_q - 31'(qs_q * 31'(lape_pkg::SIN_DIV[it_q]));
        fc   = vc_q - 31'(qc_q * 31'(lape_pkg::COS_DIV[it_q]));
        hs_q <= lape_pkg::Q30_ONE -
                ((fs >= 31'(lape_pkg::SIN_DIV[it_q])) ? qs_q + 31'd1 : qs_q);
        hc_q <= lape_pkg::Q30_ONE -
                ((fc >= 31'(lape_pkg::COS_DIV[it_q])) ? qc_q + 31'd1 : qc_q);
        it_q <= it_q + 3'd1;
      end
      lape_pkg::SC_FIN: begin
        ph   = 61'(x_q) * 61'(hs_q) + 61'h2000_0000;
        sn_q <= ph[60:30];
      end
      lape_pkg::SC_MAP: begin
        // Rotate the folded result back to its quadrant.
        s0 = neg_q ? (32'd0 - {1'b0, sn_q}) : {1'b0, sn_q};
        c0 = {1'b0, hc_q};
        case (quad_q)
          2'd0:    begin sin_q <= s0;          cos_q <= c0;          end
          2'd1:    begin sin_q <= c0;          cos_q <= 32'd0 - s0;  end
          2'd2:    begin sin_q <= 32'd0 - s0;  cos_q <= 32'd0 - c0;  end
          default: begin sin_q <= 32'd0 - c0;  cos_q <= s0;          end
        endcase
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sin  = sin_q;
  assign rsp_o.cos  = cos_q;

endmodule

### sim/tb.sv
// Self-checking testbench for line_arc_path_evaluator: clear, append and evaluate items.
// An internal fixed-point predictor works out each expected result.
// Depends on lape_pkg and the RTL in src.
`timescale 1ns / 100ps

module tb;

  localparam int          TABLE_DEPTH = lape_pkg::MAX_SEGMENTS_DEF;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          N_RANDOM    = 1700;

  // One input item, unpacked.
  typedef struct {
    logic [1:0]  op;
    logic        kind;
    logic [31:0] len;
    logic [31:0] north;
    logic [31:0] east;
    logic [15:0] heading;
    logic [31:0] curv;
    logic [31:0] pos;
  } path_cmd_t;

  // One result item, unpacked.
  typedef struct {
    logic [31:0] north;
    logic [31:0] east;
    logic [15:0] heading;
    logic [31:0] curv;
    logic [1:0]  status;
  } path_sample_t;

  // Scoreboard: keeps its own copy of the segment table and the expected samples.
  class path_scoreboard;
    logic        kind_tab [TABLE_DEPTH];
    logic [31:0] len_tab [TABLE_DEPTH];
    logic [31:0] north_tab [TABLE_DEPTH];
    logic [31:0] east_tab [TABLE_DEPTH];
    logic [15:0] head_tab [TABLE_DEPTH];
    logic [31:0] curv_tab [TABLE_DEPTH];
    logic [31:0] offs_tab [TABLE_DEPTH];
    int          seg_count;
    logic [31:0] path_total;
    path_sample_t samples_due[$];
    int          n_status [4];
    int          n_arc_evals;

    function new();
      seg_count = 0;
      path_total = 0;
      n_arc_evals = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    // Q30 product, rounded.
    function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + 64'd536870912) >> 30;
    endfunction

    // Sine and cosine of a magnitude up to one eighth of a turn.
    function void series(longint unsigned mag, output longint unsigned sn,
                         output longint unsigned cs);
      longint unsigned x, x2, hs, hc;
      longint unsigned sdv [6];
      longint unsigned cdv [6];
      sdv = '{156, 110, 72, 42, 20, 6};
      cdv = '{132, 90, 56, 30, 12, 2};
      x = (mag * 64'hC90FDAA2 + 64'd1073741824) >> 31;
      x2 = mul_q30(x, x);
      hs = 64'd1073741824;
      hc = 64'd1073741824;
      for (int i = 0; i < 6; i++) begin
        hs = 64'd1073741824 - mul_q30(x2, hs) / sdv[i];
        hc = 64'd1073741824 - mul_q30(x2, hc) / cdv[i];
      end
      sn = mul_q30(x, hs);
      cs = hc;
    endfunction

    // Sine and cosine (Q30) of a 32-bit binary angle.
    function void angle_trig(logic [31:0] a, output longint sn, output longint cs);
      logic [31:0] q, r;
      longint unsigned mag, bs, bc;
      longint s0, c0;
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      r = a - (q << 30);
      mag = r[31] ? {32'd0, 32'd0 - r} : {32'd0, r};
      series(mag, bs, bc);
      s0 = r[31] ? -longint'(bs) : longint'(bs);
      c0 = longint'(bc);
      case (q[1:0])
        2'd0: begin sn = s0;  cs = c0;  end
        2'd1: begin sn = c0;  cs = -s0; end
        2'd2: begin sn = -s0; cs = -c0; end
        default: begin sn = -c0; cs = s0; end
      endcase
    endfunction

    // Turn of the heading, k*t/(2*pi), as a 32-bit angle.
    function logic [31:0] turn_angle(longint k, longint unsigned t);
      longint unsigned p;
      logic [127:0] w;
      logic [31:0] d;
      p = (k < 0 ? longint'(-k) : k) * t;
      w = {64'd0, p} * {64'd0, 64'h28BE_60DB_9391_054A};
      d = w[95:64] + {31'd0, w[63]};
      return k < 0 ? 32'd0 - d : d;
    endfunction

    function longint scale_q30(longint v, longint f);
      longint unsigned m;
      m = longint'(v < 0 ? -v : v) * longint'(f < 0 ? -f : f);
      m = (m + 64'd536870912) >> 30;
      return ((v < 0) != (f < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint div_round(longint n, longint d);
      longint unsigned un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Note an accepted item and queue the sample it must produce.
    function void note_cmd(path_cmd_t c);
      path_sample_t r;
      logic [32:0] sum;
      logic [31:0] s, base, p1;
      longint unsigned t;
      longint k, n0, e0, sn0, cs0, sn1, cs1, pn, pe;
      int idx;
      r = '{default: '0};
      case (c.op)
        lape_pkg::OP_CLEAR: begin
          seg_count = 0;
          path_total = 0;
          r.status = lape_pkg::STAT_CLEARED;
        end
        lape_pkg::OP_APPEND: begin
          if (seg_count >= TABLE_DEPTH) begin
            r.status = lape_pkg::STAT_FULL;
          end else begin
            kind_tab[seg_count] = c.kind;
            len_tab[seg_count] = c.len;
            north_tab[seg_count] = c.north;
            east_tab[seg_count] = c.east;
            head_tab[seg_count] = c.heading;
            curv_tab[seg_count] = c.curv;
            offs_tab[seg_count] = path_total;
            sum = {1'b0, path_total} + {1'b0, c.len};
            path_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            seg_count++;
            r.status = lape_pkg::STAT_DONE;
          end
        end
        lape_pkg::OP_EVAL: begin
          if (seg_count == 0) begin
            r.status = lape_pkg::STAT_EMPTY;
          end else begin
            s = c.pos > path_total ? path_total : c.pos;
            idx = 0;
            for (int i = 0; i < seg_count; i++) if (s >= offs_tab[i]) idx = i;
            t = s - offs_tab[idx];
            if (t > len_tab[idx]) t = len_tab[idx];
            k = longint'(signed'(curv_tab[idx]));
            n0 = longint'(signed'(north_tab[idx]));
            e0 = longint'(signed'(east_tab[idx]));
            base = {head_tab[idx], 16'd0};
            angle_trig(base, sn0, cs0);
            pn = n0 + scale_q30(longint'(t), cs0);
            pe = e0 + scale_q30(longint'(t), sn0);
            if (!kind_tab[idx]) begin
              r.heading = head_tab[idx];
            end else begin
              n_arc_evals++;
              p1 = base + turn_angle(k, t);
              r.heading = 16'((p1 + 32'h8000) >> 16);
              r.curv = curv_tab[idx];
              if (k >= lape_pkg::ARC_MIN_CURV || k <= -lape_pkg::ARC_MIN_CURV) begin
                angle_trig(p1, sn1, cs1);
                pn = n0 + div_round((sn1 - sn0) * 4, k);
                pe = e0 + div_round((cs0 - cs1) * 4, k);
              end
            end
            r.north = clip32(pn);
            r.east = clip32(pe);
            r.status = lape_pkg::STAT_DONE;
          end
        end
        default: r.status = lape_pkg::STAT_DONE;
      endcase
      n_status[r.status]++;
      samples_due.push_back(r);
    endfunction

    // Compare a sample against the oldest expectation; empty string means a match.
    function string check_sample(path_sample_t got);
      path_sample_t e;
      string msg;
      if (samples_due.size() == 0) return "sample with nothing expected";
      e = samples_due.pop_front();
      msg = "";
      if (got.north !== e.north)
        msg = {msg, $sformatf(" north %h/%h", got.north, e.north)};
      if (got.east !== e.east)
        msg = {msg, $sformatf(" east %h/%h", got.east, e.east)};
      if (got.heading !== e.heading)
        msg = {msg, $sformatf(" heading %h/%h", got.heading, e.heading)};
      if (got.curv !== e.curv)
        msg = {msg, $sformatf(" curv %h/%h", got.curv, e.curv)};
      if (got.status !== e.status)
        msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
      return msg;
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  path_scoreboard sb = new();
  int  n_errors = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  n_sent = 0;

  always #5 clk_i = ~clk_i;

  line_arc_path_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic report(string msg);
    n_errors++;
    $display("tb: mismatch at %0t:%s", $time, msg);
  endtask

  // Receiver ready: random gaps, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (rst_ni) begin
      m_axis_tready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // Result monitor and stall watchdog.
  always @(posedge clk_i) begin
    path_sample_t got;
    string msg;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.north = m_axis_tdata[31:0];
        got.east = m_axis_tdata[63:32];
        got.heading = m_axis_tdata[79:64];
        got.curv = m_axis_tdata[111:80];
        got.status = m_axis_tuser;
        msg = sb.check_sample(got);
        if (msg != "") report(msg);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: timeout with %0d samples outstanding", sb.pending());
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  // Offer one item, with a random gap before it when gaps are on, and note it once accepted.
  task automatic send_cmd(path_cmd_t c);
    if (gaps_on) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tdata = {c.pos, c.curv, c.heading, c.east, c.north, c.len};
    s_axis_tuser = {c.kind, c.op};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_cmd(c);
    n_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic path_cmd_t mk_cmd(logic [1:0] op);
    path_cmd_t c;
    c.op = op;
    c.kind = 1'($urandom_range(1));
    c.len = $urandom;
    c.north = $urandom;
    c.east = $urandom;
    c.heading = 16'($urandom);
    c.curv = $urandom;
    c.pos = $urandom;
    return c;
  endfunction

  // A segment of plausible size, with now and then full-range fields.
  function automatic path_cmd_t mk_segment();
    path_cmd_t c;
    int sel;
    c = mk_cmd(lape_pkg::OP_APPEND);
    sel = $urandom_range(9);
    if (sel < 6) begin
      c.len = $urandom_range(65535);
      c.north = $signed($urandom_range(2000000)) - 1000000;
      c.east = $signed($urandom_range(2000000)) - 1000000;
    end
    sel = $urandom_range(9);
    if (sel < 5) c.curv = $signed($urandom_range(1 << 25)) - (1 << 24);
    else if (sel < 7) c.curv = $signed($urandom_range(40)) - 20;
    return c;
  endfunction

  task automatic send_eval(logic [31:0] pos);
    path_cmd_t c;
    c = mk_cmd(lape_pkg::OP_EVAL);
    c.pos = pos;
    send_cmd(c);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Directed part: every operation and the corner cases.
  task automatic directed_cases();
    path_cmd_t c;
    send_cmd(mk_cmd(lape_pkg::OP_CLEAR));
    send_eval(32'd0);
    send_cmd(mk_cmd(OP_UNUSED));
    c = mk_segment();
    c.kind = 1'b0;
    c.len = 32'd1000;
    c.north = 32'h7FFF_FF00;
    c.east = 32'h8000_0000;
    c.heading = 16'h2000;
    send_cmd(c);
    send_eval(32'd0);
    send_eval(32'd1000);
    c.kind = 1'b1;
    c.curv = 32'sd16;
    c.north = 0;
    c.east = 0;
    send_cmd(c);
    send_eval(32'd1500);
    c.curv = -32'sd17;
    send_cmd(c);
    send_eval(32'd2700);
    c.curv = 32'h7FFF_FFFF;
    c.heading = 16'hFFFF;
    send_cmd(c);
    c.curv = 32'h8000_0000;
    c.len = 32'hFFFF_FFFF;
    c.heading = 16'h0000;
    send_cmd(c);
    send_eval(32'd3500);
    send_eval(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_cmd(mk_segment());
    send_cmd(mk_segment());
    send_eval($urandom);
    send_cmd(mk_cmd(lape_pkg::OP_CLEAR));
    send_eval(32'd5);
  endtask

  initial begin
    int seq_n, n_evals;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    directed_cases();

    // Random sequences: clear, fill, then sample along the path, or now and then one random item.
    while (n_sent < N_RANDOM + 25) begin
      gaps_on = !(n_sent > 800 && n_sent < 1000);
      if (n_sent > 400 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        send_cmd(mk_cmd(2'($urandom_range(3))));
      end else begin
        send_cmd(mk_cmd(lape_pkg::OP_CLEAR));
        seq_n = $urandom_range(1, TABLE_DEPTH + 1);
        for (int i = 0; i < seq_n; i++) send_cmd(mk_segment());
        n_evals = $urandom_range(1, 8);
        for (int i = 0; i < n_evals; i++) begin
          if ($urandom_range(9) < 8) send_eval(sb.path_total == 0 ? 0 :
                                               $urandom_range(sb.path_total));
          else send_eval($urandom);
        end
      end
      if ($urandom_range(49) == 0) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("tb: %0d items sent: %0d done, %0d full drops, %0d empty, %0d clears",
             n_sent, sb.n_status[lape_pkg::STAT_DONE], sb.n_status[lape_pkg::STAT_FULL],
             sb.n_status[lape_pkg::STAT_EMPTY], sb.n_status[lape_pkg::STAT_CLEARED]);
    $display("tb: %0d samples on arcs, %0d mismatches", sb.n_arc_evals, n_errors);
    if (n_errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
